### src/hsl_to_rgb_converter_macros.svh
`ifndef HSL_TO_RGB_CONVERTER_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_MACROS_SVH

// checked only outside reset
`define HSL2RGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// checked on every edge, reset included
`define HSL2RGB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

### src/hsl2rgb_pkg.sv
package hsl2rgb_pkg;

  localparam int FRAC_BITS = 20;
  localparam int FW = FRAC_BITS + 1;
  localparam int QW = FRAC_BITS + 2;
  localparam int TW = FRAC_BITS + 3;
  localparam int XW = FRAC_BITS + 3;
  localparam int VW = FRAC_BITS + 3;
  localparam int PW = QW + XW + 1;
  localparam int CW = VW + 9;
  localparam int HUE_SHIFT = FRAC_BITS - 3;

  localparam int NUM_STAGES = 6;
  localparam int NUM_CHANNELS = 3;

  localparam int HUE_MAX = 360;
  localparam int PCT_MAX = 100;
  localparam int HUE_SECTOR = 45;
  localparam int HUE_SECTORS = 8;
  localparam int CHAN_MAX = 255;
  localparam logic [9:0] GRAY_GAIN = 10'd653;

  localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;
  localparam logic [FW-1:0] ONE = FW'(ONE_L);
  localparam logic [FW-1:0] HALF = FW'(ONE_L >> 1);
  localparam logic [FW-1:0] THIRD = FW'((ONE_L + 64'd1) / 64'd3);
  localparam logic [FW-1:0] SIXTH = FW'((ONE_L + 64'd3) / 64'd6);
  localparam logic [FW-1:0] TWO_THIRDS = FW'((64'd2 * ONE_L + 64'd1) / 64'd3);

  typedef struct packed {
    logic [8:0] hue_degrees;
    logic [6:0] saturation_pct;
    logic [6:0] lightness_pct;
  } hsl_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } ramp_seg_t;

  typedef struct packed {
    ramp_seg_t       seg;
    logic [XW-1:0]   x;
  } ramp_pos_t;

  // wrap the hue position once, pick the ramp segment and its slope factor
  function automatic ramp_pos_t ramp_pos(input logic signed [TW-1:0] t_raw);
    logic signed [TW-1:0] t;
    logic [XW-1:0] tu;
    logic [XW-1:0] fall;
    ramp_pos_t r;
    t = t_raw;
    if (t < $signed(TW'(0))) begin
      t = t + $signed(TW'(ONE));
    end else if (t > $signed(TW'(ONE))) begin
      t = t - $signed(TW'(ONE));
    end
    tu = XW'($unsigned(t));
    fall = XW'(TWO_THIRDS) - tu;
    r.x = '0;
    priority if (tu < XW'(SIXTH)) begin
      r.seg = SEG_RISE;
      r.x = (tu << 2) + (tu << 1);
    end else if (tu < XW'(HALF)) begin
      r.seg = SEG_HIGH;
    end else if (tu < XW'(TWO_THIRDS)) begin
      r.seg = SEG_FALL;
      r.x = (fall << 2) + (fall << 1);
    end else begin
      r.seg = SEG_LOW;
    end
    return r;
  endfunction

endpackage

### src/hsl_to_rgb_converter.sv
// hsl to rgb converter, pixel stream
// an accepted request passes through every register stage on its way to its result
// throughput: one request per cycle while rgb_stall stays low
// rgb_stall holds every full stage with no empty stage after it; a request is taken whenever the first stage has room
// rst clears all stage valid bits; payload registers are not reset
module hsl_to_rgb_converter (
  input  logic               clk,
  input  logic               rst,
  input  logic               hsl_valid,
  output logic               hsl_stall,
  input  hsl2rgb_pkg::hsl_t  hsl,
  output logic               rgb_valid,
  input  logic               rgb_stall,
  output hsl2rgb_pkg::rgb_t  rgb
);

  logic [hsl2rgb_pkg::NUM_STAGES-1:0] vld;
  logic [hsl2rgb_pkg::NUM_STAGES-1:0] vld_next;
  logic [hsl2rgb_pkg::NUM_STAGES-1:0] rdy;

  assign rdy[hsl2rgb_pkg::NUM_STAGES-1] = !vld[hsl2rgb_pkg::NUM_STAGES-1] || !rgb_stall;
  for (genvar k = 0; k < hsl2rgb_pkg::NUM_STAGES - 1; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  assign vld_next = (vld & ~rdy)
                  | ({vld[hsl2rgb_pkg::NUM_STAGES-2:0], hsl_valid} & rdy);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign hsl_stall = !rdy[0];
  assign rgb_valid = vld[hsl2rgb_pkg::NUM_STAGES-1];

  // stage 1: clamp, percent and hue to fractions, gray value
  logic [hsl2rgb_pkg::FW-1:0] pct_tab [hsl2rgb_pkg::PCT_MAX+1];
  logic [hsl2rgb_pkg::FW-1:0] hue_tab [hsl2rgb_pkg::HUE_SECTOR];

  for (genvar i = 0; i <= hsl2rgb_pkg::PCT_MAX; i++) begin : g_pct
    assign pct_tab[i] = hsl2rgb_pkg::FW'(((64'(i) << hsl2rgb_pkg::FRAC_BITS)
                        + 64'(hsl2rgb_pkg::PCT_MAX / 2)) / 64'(hsl2rgb_pkg::PCT_MAX));
  end
  for (genvar i = 0; i < hsl2rgb_pkg::HUE_SECTOR; i++) begin : g_hue
    assign hue_tab[i] = hsl2rgb_pkg::FW'(((64'(i) << hsl2rgb_pkg::HUE_SHIFT)
                        + 64'((hsl2rgb_pkg::HUE_MAX / 2) >> 3))
                        / 64'(hsl2rgb_pkg::HUE_SECTOR));
  end

  logic [8:0] hue_c;
  logic [6:0] sat_c;
  logic [6:0] lit_c;
  logic [3:0] sector;
  logic [8:0] sector_base;
  logic [5:0] hue_rem;
  logic [15:0] gray_prod;

  always_comb begin
    hue_c = (hsl.hue_degrees > 9'(hsl2rgb_pkg::HUE_MAX)) ? 9'(hsl2rgb_pkg::HUE_MAX)
                                                         : hsl.hue_degrees;
    sat_c = (hsl.saturation_pct > 7'(hsl2rgb_pkg::PCT_MAX)) ? 7'(hsl2rgb_pkg::PCT_MAX)
                                                           : hsl.saturation_pct;
    lit_c = (hsl.lightness_pct > 7'(hsl2rgb_pkg::PCT_MAX)) ? 7'(hsl2rgb_pkg::PCT_MAX)
                                                          : hsl.lightness_pct;
    sector = '0;
    for (int i = 1; i <= hsl2rgb_pkg::HUE_SECTORS; i++) begin
      if (hue_c >= 9'(i * hsl2rgb_pkg::HUE_SECTOR)) begin
        sector = 4'(i);
      end
    end
    sector_base = 9'(sector) * 9'(hsl2rgb_pkg::HUE_SECTOR);
    hue_rem = 6'(hue_c - sector_base);
    gray_prod = 16'(lit_c) * 16'(hsl2rgb_pkg::GRAY_GAIN);
  end

  logic [hsl2rgb_pkg::FW-1:0] h1, s1, l1;
  logic                       gray1;
  logic [7:0]                 gval1;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      h1 <= (hsl2rgb_pkg::FW'(sector) << hsl2rgb_pkg::HUE_SHIFT) + hue_tab[hue_rem];
      s1 <= pct_tab[sat_c];
      l1 <= pct_tab[lit_c];
      gray1 <= (sat_c == '0);
      gval1 <= gray_prod[15:8];
    end
  end

  // stage 2: l*s
  logic [2*hsl2rgb_pkg::FW-1:0] m2;
  logic [hsl2rgb_pkg::FW-1:0]   h2, s2, l2;
  logic                         gray2;
  logic [7:0]                   gval2;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      m2 <= (2*hsl2rgb_pkg::FW)'(l1) * (2*hsl2rgb_pkg::FW)'(s1);
      h2 <= h1;
      s2 <= s1;
      l2 <= l1;
      gray2 <= gray1;
      gval2 <= gval1;
    end
  end

  // stage 3: q, channel hue positions
  logic [hsl2rgb_pkg::FW-1:0] ls_rnd;
  logic [hsl2rgb_pkg::QW-1:0] q_c;
  logic signed [hsl2rgb_pkg::TW-1:0] t_raw [hsl2rgb_pkg::NUM_CHANNELS];

  always_comb begin
    ls_rnd = hsl2rgb_pkg::FW'((m2 + (2*hsl2rgb_pkg::FW)'(hsl2rgb_pkg::HALF))
                              >> hsl2rgb_pkg::FRAC_BITS);
    if (l2 < hsl2rgb_pkg::HALF) begin
      q_c = hsl2rgb_pkg::QW'(l2) + hsl2rgb_pkg::QW'(ls_rnd);
    end else begin
      q_c = hsl2rgb_pkg::QW'(l2) + hsl2rgb_pkg::QW'(s2) - hsl2rgb_pkg::QW'(ls_rnd);
    end
  end

  assign t_raw[0] = $signed(hsl2rgb_pkg::TW'(h2))
                  + $signed(hsl2rgb_pkg::TW'(hsl2rgb_pkg::THIRD));
  assign t_raw[1] = $signed(hsl2rgb_pkg::TW'(h2));
  assign t_raw[2] = $signed(hsl2rgb_pkg::TW'(h2))
                  - $signed(hsl2rgb_pkg::TW'(hsl2rgb_pkg::THIRD));

  logic [hsl2rgb_pkg::QW-1:0] q3, ll3;
  logic                       gray3;
  logic [7:0]                 gval3;
  hsl2rgb_pkg::ramp_pos_t     pos3 [hsl2rgb_pkg::NUM_CHANNELS];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      q3 <= q_c;
      ll3 <= hsl2rgb_pkg::QW'(l2) << 1;
      gray3 <= gray2;
      gval3 <= gval2;
    end
  end

  // stage 4: p and d
  logic [hsl2rgb_pkg::QW-1:0] p_c, d_c;

  always_comb begin
    p_c = (ll3 > q3) ? ll3 - q3 : '0;
    d_c = (q3 > p_c) ? q3 - p_c : '0;
  end

  logic [hsl2rgb_pkg::QW-1:0] p4, q4, d4;
  logic                       gray4;
  logic [7:0]                 gval4;
  hsl2rgb_pkg::ramp_pos_t     pos4 [hsl2rgb_pkg::NUM_CHANNELS];

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      p4 <= p_c;
      q4 <= q3;
      d4 <= d_c;
      gray4 <= gray3;
      gval4 <= gval3;
    end
  end

  // stage 5: d times slope factor
  logic [hsl2rgb_pkg::QW-1:0] p5, q5;
  logic                       gray5;
  logic [7:0]                 gval5;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      p5 <= p4;
      q5 <= q4;
      gray5 <= gray4;
      gval5 <= gval4;
    end
  end

  // stage 6: ramp value, scale to 8 bits, round, clamp; gray value when saturation is zero
  logic [7:0] chan [hsl2rgb_pkg::NUM_CHANNELS];

  for (genvar c = 0; c < hsl2rgb_pkg::NUM_CHANNELS; c++) begin : g_chan
    hsl2rgb_pkg::ramp_seg_t        seg5;
    logic [hsl2rgb_pkg::PW-1:0]    prod5;
    logic [hsl2rgb_pkg::VW-1:0]    ramp_v;
    logic [hsl2rgb_pkg::CW-1:0]    scaled;

    always_ff @(posedge clk) begin
      if (rdy[2]) begin
        pos3[c] <= hsl2rgb_pkg::ramp_pos(t_raw[c]);
      end
      if (rdy[3]) begin
        pos4[c] <= pos3[c];
      end
      if (rdy[4]) begin
        seg5 <= pos4[c].seg;
        prod5 <= hsl2rgb_pkg::PW'(d4) * hsl2rgb_pkg::PW'(pos4[c].x);
      end
    end

    always_comb begin
      unique case (seg5)
        hsl2rgb_pkg::SEG_RISE, hsl2rgb_pkg::SEG_FALL: begin
          ramp_v = hsl2rgb_pkg::VW'(p5)
                 + hsl2rgb_pkg::VW'((prod5 + hsl2rgb_pkg::PW'(hsl2rgb_pkg::HALF))
                                    >> hsl2rgb_pkg::FRAC_BITS);
        end
        hsl2rgb_pkg::SEG_HIGH: ramp_v = hsl2rgb_pkg::VW'(q5);
        default:               ramp_v = hsl2rgb_pkg::VW'(p5);
      endcase
      scaled = ((hsl2rgb_pkg::CW'(ramp_v) << 8) - hsl2rgb_pkg::CW'(ramp_v)
               + hsl2rgb_pkg::CW'(hsl2rgb_pkg::HALF)) >> hsl2rgb_pkg::FRAC_BITS;
      if (gray5) begin
        chan[c] = gval5;
      end else if (scaled > hsl2rgb_pkg::CW'(hsl2rgb_pkg::CHAN_MAX)) begin
        chan[c] = 8'(hsl2rgb_pkg::CHAN_MAX);
      end else begin
        chan[c] = scaled[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      rgb.red <= chan[0];
      rgb.green <= chan[1];
      rgb.blue <= chan[2];
    end
  end

endmodule

### src/hsl2rgb_chk.sv
`include "hsl_to_rgb_converter_macros.svh"

module hsl2rgb_chk (
  input logic              clk,
  input logic              rst,
  input logic              hsl_valid,
  input logic              hsl_stall,
  input logic              rgb_valid,
  input logic              rgb_stall,
  input hsl2rgb_pkg::rgb_t rgb
);

  `HSL2RGB_ASSERT_ALWAYS(a_reset_empties, rst |=> !rgb_valid, "result valid right after reset")

  `HSL2RGB_ASSERT(a_result_holds, rgb_valid && rgb_stall |=> rgb_valid && $stable(rgb), "stalled result changed")

  // back pressure on the input only comes from a stalled output
  `HSL2RGB_ASSERT(a_stall_source, !rgb_stall |-> !hsl_stall, "input stalled while output flows")

  // a result after an empty output slot went through the pipe without a hold
  `HSL2RGB_ASSERT(a_latency, $rose(rgb_valid) |-> $past(hsl_valid && !hsl_stall, hsl2rgb_pkg::NUM_STAGES), "result without request at pipeline depth")

endmodule

bind hsl_to_rgb_converter hsl2rgb_chk u_hsl2rgb_chk (
  .clk       (clk),
  .rst       (rst),
  .hsl_valid (hsl_valid),
  .hsl_stall (hsl_stall),
  .rgb_valid (rgb_valid),
  .rgb_stall (rgb_stall),
  .rgb       (rgb)
);

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ROWS = 25;
  localparam int NUM_RANDOM = 1000;
  localparam int QUIET_FROM = 880;
  localparam int HOLD_AT = 400;
  localparam int HOLD_LEN = 48;
  localparam int STUCK_LIMIT = 2000;
  localparam int PX_BITS = $bits(hsl2rgb_pkg::hsl_t);

  localparam longint unsigned UNIT = hsl2rgb_pkg::ONE_L;
  localparam longint UNIT_S = longint'(hsl2rgb_pkg::ONE_L);
  localparam longint THIRD_T = longint'((hsl2rgb_pkg::ONE_L + 1) / 3);
  localparam longint SIXTH_T = longint'((hsl2rgb_pkg::ONE_L + 3) / 6);
  localparam longint HALF_T = longint'(hsl2rgb_pkg::ONE_L / 2);
  localparam longint TWO_THIRDS_T = longint'((2 * hsl2rgb_pkg::ONE_L + 1) / 3);

  typedef struct {
    hsl2rgb_pkg::hsl_t px;
    bit                known;
    hsl2rgb_pkg::rgb_t rgb;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;
  logic hsl_valid = 1'b0;
  logic hsl_stall;
  hsl2rgb_pkg::hsl_t hsl = '0;
  logic rgb_valid;
  logic rgb_stall = 1'b0;
  hsl2rgb_pkg::rgb_t rgb;

  hsl2rgb_pkg::rgb_t rgb_expected[$];
  hsl2rgb_pkg::rgb_t want;
  int mismatches = 0;
  int stuck = 0;
  int turns = 0;
  bit quiet = 1'b0;

  // hue, saturation, lightness; known result where it is plain to see
  stim_row_t stim_rows [NUM_ROWS] = '{
    '{'{9'd0,   7'd0,   7'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{'{9'd0,   7'd0,   7'd100}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{'{9'd200, 7'd0,   7'd50},  1'b1, '{8'd127, 8'd127, 8'd127}},
    '{'{9'd511, 7'd0,   7'd127}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{'{9'd0,   7'd100, 7'd50},  1'b1, '{8'd255, 8'd0,   8'd0}},
    '{'{9'd120, 7'd100, 7'd50},  1'b1, '{8'd0,   8'd255, 8'd0}},
    '{'{9'd360, 7'd100, 7'd50},  1'b1, '{8'd255, 8'd0,   8'd0}},
    '{'{9'd0,   7'd100, 7'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{'{9'd0,   7'd100, 7'd100}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{'{9'd240, 7'd100, 7'd50},  1'b0, '0},
    '{'{9'd60,  7'd100, 7'd50},  1'b0, '0},
    '{'{9'd180, 7'd100, 7'd50},  1'b0, '0},
    '{'{9'd300, 7'd100, 7'd50},  1'b0, '0},
    '{'{9'd30,  7'd127, 7'd50},  1'b0, '0},
    '{'{9'd90,  7'd100, 7'd127}, 1'b0, '0},
    '{'{9'd511, 7'd127, 7'd127}, 1'b0, '0},
    '{'{9'd361, 7'd40,  7'd30},  1'b0, '0},
    '{'{9'd1,   7'd1,   7'd1},   1'b0, '0},
    '{'{9'd359, 7'd99,  7'd99},  1'b0, '0},
    '{'{9'd45,  7'd50,  7'd25},  1'b0, '0},
    '{'{9'd210, 7'd75,  7'd75},  1'b0, '0},
    '{'{9'h0ff, 7'h55,  7'h2a},  1'b0, '0},
    '{'{9'h100, 7'h2a,  7'h55},  1'b0, '0},
    '{'{9'd150, 7'd1,   7'd99},  1'b0, '0},
    '{'{9'd20,  7'd100, 7'd49},  1'b0, '0}
  };

  hsl_to_rgb_converter u_top (
    .clk       (clk),
    .rst       (rst),
    .hsl_valid (hsl_valid),
    .hsl_stall (hsl_stall),
    .hsl       (hsl),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb       (rgb)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned ramp_level(input longint unsigned p,
                                                 input longint unsigned q,
                                                 input longint pos);
    longint unsigned d;
    longint t;
    d = (q > p) ? q - p : 64'd0;
    t = pos;
    if (t < 0) begin
      t = t + UNIT_S;
    end
    if (t > UNIT_S) begin
      t = t - UNIT_S;
    end
    if (t < SIXTH_T) begin
      return p + ((d * 6 * $unsigned(t) + UNIT / 2) >> hsl2rgb_pkg::FRAC_BITS);
    end
    if (t < HALF_T) begin
      return q;
    end
    if (t < TWO_THIRDS_T) begin
      return p + ((d * 6 * $unsigned(TWO_THIRDS_T - t) + UNIT / 2)
                  >> hsl2rgb_pkg::FRAC_BITS);
    end
    return p;
  endfunction

  function automatic logic [7:0] level_to_chan(input longint unsigned v);
    longint unsigned c;
    c = (255 * v + UNIT / 2) >> hsl2rgb_pkg::FRAC_BITS;
    if (c > 64'(hsl2rgb_pkg::CHAN_MAX)) begin
      c = 64'(hsl2rgb_pkg::CHAN_MAX);
    end
    return 8'(c);
  endfunction

  function automatic hsl2rgb_pkg::rgb_t hsl_to_rgb(input hsl2rgb_pkg::hsl_t px);
    longint unsigned hue, sat, lit, h, s, l, q, p, g;
    hsl2rgb_pkg::rgb_t c;
    hue = (px.hue_degrees > 9'(hsl2rgb_pkg::HUE_MAX)) ? 64'(hsl2rgb_pkg::HUE_MAX)
                                                       : 64'(px.hue_degrees);
    sat = (px.saturation_pct > 7'(hsl2rgb_pkg::PCT_MAX)) ? 64'(hsl2rgb_pkg::PCT_MAX)
                                                          : 64'(px.saturation_pct);
    lit = (px.lightness_pct > 7'(hsl2rgb_pkg::PCT_MAX)) ? 64'(hsl2rgb_pkg::PCT_MAX)
                                                         : 64'(px.lightness_pct);
    if (sat == 0) begin
      g = (lit * 64'(hsl2rgb_pkg::GRAY_GAIN)) >> 8;
      if (g > 64'(hsl2rgb_pkg::CHAN_MAX)) begin
        g = 64'(hsl2rgb_pkg::CHAN_MAX);
      end
      c.red = 8'(g);
      c.green = 8'(g);
      c.blue = 8'(g);
      return c;
    end
    h = (hue * UNIT + 64'(hsl2rgb_pkg::HUE_MAX / 2)) / 64'(hsl2rgb_pkg::HUE_MAX);
    s = (sat * UNIT + 64'(hsl2rgb_pkg::PCT_MAX / 2)) / 64'(hsl2rgb_pkg::PCT_MAX);
    l = (lit * UNIT + 64'(hsl2rgb_pkg::PCT_MAX / 2)) / 64'(hsl2rgb_pkg::PCT_MAX);
    if (l < UNIT / 2) begin
      q = (l * (UNIT + s) + UNIT / 2) >> hsl2rgb_pkg::FRAC_BITS;
    end else begin
      q = l + s - ((l * s + UNIT / 2) >> hsl2rgb_pkg::FRAC_BITS);
    end
    p = (2 * l > q) ? 2 * l - q : 64'd0;
    c.red = level_to_chan(ramp_level(p, q, longint'(h) + THIRD_T));
    c.green = level_to_chan(ramp_level(p, q, longint'(h)));
    c.blue = level_to_chan(ramp_level(p, q, longint'(h) - THIRD_T));
    return c;
  endfunction

  function automatic hsl2rgb_pkg::hsl_t random_pixel();
    hsl2rgb_pkg::hsl_t px;
    px.hue_degrees = 9'($urandom_range(0, hsl2rgb_pkg::HUE_MAX));
    px.saturation_pct = 7'($urandom_range(1, hsl2rgb_pkg::PCT_MAX));
    px.lightness_pct = 7'($urandom_range(0, hsl2rgb_pkg::PCT_MAX));
    case ($urandom_range(0, 9))
      0: px = PX_BITS'($urandom);
      1: px.saturation_pct = '0;
      2: px.hue_degrees = ($urandom_range(0, 1) != 0) ? 9'(hsl2rgb_pkg::HUE_MAX) : 9'd0;
      3: px.lightness_pct = ($urandom_range(0, 1) != 0) ? 7'(hsl2rgb_pkg::PCT_MAX) : 7'd0;
      default: ;
    endcase
    return px;
  endfunction

  task automatic send_request(input hsl2rgb_pkg::hsl_t px, input bit known,
                              input hsl2rgb_pkg::rgb_t known_rgb);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      hsl_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    hsl <= px;
    hsl_valid <= 1'b1;
    do @(posedge clk); while (hsl_stall !== 1'b0);
    rgb_expected.push_back(known ? known_rgb : hsl_to_rgb(px));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_request(stim_rows[i].px, stim_rows[i].known, stim_rows[i].rgb);
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == QUIET_FROM) begin
        quiet = 1'b1;
      end
      send_request(random_pixel(), 1'b0, '0);
    end
    hsl_valid <= 1'b0;
    while (rgb_expected.size() != 0) @(posedge clk);
    repeat (2 * hsl2rgb_pkg::NUM_STAGES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver side, with one long hold-off to back the pipe up
  initial begin
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      turns++;
      if (turns == HOLD_AT) begin
        rgb_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        rgb_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rgb_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        rgb_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rgb_valid === 1'b1 && !rgb_stall) begin
      if (rgb_expected.size() == 0) begin
        $error("result with no request pending: %0d %0d %0d", rgb.red, rgb.green, rgb.blue);
        mismatches++;
      end else begin
        want = rgb_expected.pop_front();
        if (rgb.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, rgb.red);
          mismatches++;
        end
        if (rgb.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, rgb.green);
          mismatches++;
        end
        if (rgb.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, rgb.blue);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (hsl_valid && hsl_stall === 1'b0) || (rgb_valid === 1'b1 && !rgb_stall)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

endmodule
